// ===== rtl/aar_pkg.sv =====
`timescale 1ns / 1ps

package aar_pkg;

    // Fixed-point one in Q2.30.
    localparam logic signed [31:0] ONE30 = 32'sd1073741824;

    // Indexes of the axis products u_a * u_b.
    localparam int UU_XX = 0;
    localparam int UU_YY = 1;
    localparam int UU_ZZ = 2;
    localparam int UU_XY = 3;
    localparam int UU_XZ = 4;
    localparam int UU_YZ = 5;

    // Indexes of the axis-times-sine products.
    localparam int US_X = 0;
    localparam int US_Y = 1;
    localparam int US_Z = 2;

    // Unsigned 64-bit long division by shift and subtract, for elaboration-time constants.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b,
                                           input logic want_rem);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b})
            begin
                r = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return want_rem ? r[63:0] : q;
    endfunction

    // Floor square root of a 64-bit value, for elaboration-time constants.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n = n_in;
        res = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++)
        begin
            if (bitv > n)
                bitv = bitv >> 2;
        end
        for (int j = 0; j < 32; j++)
        begin
            if (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // atan(1/n) in Q62 from its alternating power series.
    function automatic logic [63:0] atan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] k;
        sum = '0;
        k = '0;
        p = udiv64(64'h4000_0000_0000_0000, n, 1'b0);
        for (int j = 0; j < 64; j++)
        begin
            if (p != 0)
            begin
                term = udiv64(p, 64'(2 * k + 1), 1'b0);
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
                p = udiv64(udiv64(p, n, 1'b0), n, 1'b0);
                k = k + 1;
            end
        end
        return sum;
    endfunction

    // Pi in Q60, as atan(1/2) + atan(1/3) in Q62.
    localparam logic [63:0] PI60 = atan_recip(64'd2) + atan_recip(64'd3);
    localparam logic [55:0] TWOPI48 = 56'(PI60 >> 11);
    localparam logic [55:0] HALFPI48 = 56'(PI60 >> 13);

    // CORDIC angle for step i, atan(2^-i) in Q48.
    function automatic logic signed [52:0] atan48(input int i);
        logic [63:0] a62;
        if (i == 0)
            a62 = PI60;
        else if (i < 62)
            a62 = atan_recip(64'd1 << i);
        else
            a62 = '0;
        return 53'(a62 >> 14);
    endfunction

    // Reciprocal of the CORDIC gain in Q40.
    function automatic logic signed [43:0] cordic_k40(input int steps);
        logic [63:0] gain;
        logic [63:0] sg;
        logic [63:0] q1;
        logic [63:0] rm;
        gain = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 64; i++)
        begin
            if (i < steps && 2 * i < 64)
                gain = gain + (gain >> (2 * i));
        end
        sg = isqrt64(gain);
        q1 = udiv64(64'h8000_0000_0000_0000, sg, 1'b0);
        rm = udiv64(64'h8000_0000_0000_0000, sg, 1'b1);
        return 44'((q1 << 8) + udiv64(rm << 8, sg, 1'b0));
    endfunction

    // Product of two Q30 values, rounded half up back to Q30.
    function automatic logic signed [35:0] mul30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b + (66'sd1 <<< 29);
        return $signed(p[65:30]);
    endfunction

    // Clamp to [-1, 1] in Q2.30.
    function automatic logic signed [31:0] clamp30(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'sd1073741824)
            res = ONE30;
        else if (v < -36'sd1073741824)
            res = -ONE30;
        else
            res = 32'(v);
        return res;
    endfunction

    typedef struct packed {
        logic [2:0][63:0] sq;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } front_t;

    typedef struct packed {
        logic [63:0]      n;
        logic [33:0]      rem;
        logic [31:0]      root;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } sqrt_stage_t;

    typedef struct packed {
        logic [31:0]      len;
        logic [2:0][31:0] rem;
        logic [2:0]       lsb;
        logic [2:0][30:0] q;
        logic [2:0]       neg;
        logic             zero;
        logic [55:0]      r;
        logic [1:0]       quad;
    } div_stage_t;

    typedef struct packed {
        logic signed [43:0] x;
        logic signed [43:0] y;
        logic signed [52:0] z;
        logic [2:0][31:0]   u;
        logic [1:0]         quad;
        logic               zero;
    } cordic_stage_t;

    typedef struct packed {
        logic signed [31:0] cs;
        logic signed [31:0] sn;
        logic signed [32:0] t;
        logic [2:0][31:0]   u;
        logic               zero;
    } post1_t;

    typedef struct packed {
        logic signed [31:0] cs;
        logic signed [32:0] t;
        logic [5:0][31:0]   uu;
        logic [2:0][31:0]   us;
        logic               zero;
    } post2_t;

    typedef struct packed {
        logic signed [31:0] cs;
        logic [5:0][32:0]   ut;
        logic [2:0][31:0]   us;
        logic               zero;
    } post3_t;

    typedef logic [8:0][31:0] matrix_t;

endpackage

// ===== rtl/axis_angle_to_rotation.sv =====
`timescale 1ns / 1ps
// The pipeline holds the 32 square-root stages, 31 divider stages and one stage per CORDIC step.
// Throughput: one item per cycle while the skid register is empty; an output skid register holds one extra result.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module axis_angle_to_rotation #(
    parameter int CORDIC_STEPS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m02,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] m12,
    output logic signed [31:0] m20,
    output logic signed [31:0] m21,
    output logic signed [31:0] m22
);

    localparam int NPIPE = 68 + CORDIC_STEPS;
    localparam logic signed [43:0] K40 = aar_pkg::cordic_k40(CORDIC_STEPS);

    logic                 en;
    logic [NPIPE-1:0]     vld_reg;
    logic                 skid_valid_reg;
    logic                 out_valid_reg;
    aar_pkg::matrix_t     out_reg;
    aar_pkg::matrix_t     skid_reg;
    aar_pkg::matrix_t     res_next;

    aar_pkg::front_t        front_reg;
    aar_pkg::front_t        front_next;
    aar_pkg::sqrt_stage_t   sqrt_reg [0:32];
    aar_pkg::sqrt_stage_t   sqrt_start;
    aar_pkg::div_stage_t    div_reg [1:31];
    aar_pkg::div_stage_t    div_start;
    aar_pkg::cordic_stage_t cordic_reg [1:CORDIC_STEPS];
    aar_pkg::cordic_stage_t cordic_start;
    aar_pkg::post1_t        post1_reg;
    aar_pkg::post1_t        post1_next;
    aar_pkg::post2_t        post2_reg;
    aar_pkg::post2_t        post2_next;
    aar_pkg::post3_t        post3_reg;
    aar_pkg::post3_t        post3_next;

    // The pipeline advances whenever the skid register is empty.
    assign en = ~skid_valid_reg;
    assign in_ready = en;

    // Valid bits travel down the pipeline with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NPIPE-2:0], in_valid};
    end

    // Magnitudes and squares of the components.
    always_comb
    begin
        logic [2:0][31:0] c;
        c = {axis_z, axis_y, axis_x};
        for (int k = 0; k < 3; k++)
        begin
            front_next.neg[k] = c[k][31];
            front_next.mag[k] = c[k][31] ? (~c[k] + 32'd1) : c[k];
            front_next.sq[k] = 64'(front_next.mag[k]) * 64'(front_next.mag[k]);
        end
        front_next.zero = (axis_x == 32'sd0) && (axis_y == 32'sd0) && (axis_z == 32'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    // Sum of squares seeds the square-root pipeline.
    always_comb
    begin
        sqrt_start.n = front_reg.sq[0] + front_reg.sq[1] + front_reg.sq[2];
        sqrt_start.rem = '0;
        sqrt_start.root = '0;
        sqrt_start.mag = front_reg.mag;
        sqrt_start.neg = front_reg.neg;
        sqrt_start.zero = front_reg.zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sqrt_reg[0] <= sqrt_start;
    end

    // Floor square root, one result bit per stage.
    for (genvar j = 0; j < 32; j++)
    begin : g_sqrt
        aar_pkg::sqrt_stage_t sqrt_next;
        logic [35:0]          acc;
        logic [35:0]          trial;

        always_comb
        begin
            sqrt_next = sqrt_reg[j];
            acc = {sqrt_reg[j].rem, sqrt_reg[j].n[63-2*j -: 2]};
            trial = {2'b00, sqrt_reg[j].root, 2'b01};
            if (acc >= trial)
            begin
                sqrt_next.rem = 34'(acc - trial);
                sqrt_next.root = {sqrt_reg[j].root[30:0], 1'b1};
            end
            else
            begin
                sqrt_next.rem = 34'(acc);
                sqrt_next.root = {sqrt_reg[j].root[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sqrt_reg[j+1] <= sqrt_next;
        end
    end

    // Divider and angle-reduction seed from the length.
    always_comb
    begin
        div_start.len = sqrt_reg[32].root;
        for (int k = 0; k < 3; k++)
        begin
            div_start.rem[k] = {1'b0, sqrt_reg[32].mag[k][31:1]};
            div_start.lsb[k] = sqrt_reg[32].mag[k][0];
            div_start.q[k] = '0;
        end
        div_start.neg = sqrt_reg[32].neg;
        div_start.zero = sqrt_reg[32].zero;
        div_start.r = {sqrt_reg[32].root, 24'd0};
        div_start.quad = '0;
    end

    // Unit axis by restoring division, one quotient bit per stage. The first
    // eight stages also reduce the angle modulo two pi and find the quadrant.
    for (genvar d = 0; d < 31; d++)
    begin : g_div
        localparam logic [56:0] RED_SUB = (d < 6) ? (57'(aar_pkg::TWOPI48) << (5 - d)) :
                                          (d == 6) ? (57'(aar_pkg::HALFPI48) << 1) :
                                          57'(aar_pkg::HALFPI48);
        aar_pkg::div_stage_t cur;
        aar_pkg::div_stage_t div_next;

        if (d == 0)
        begin : g_first
            assign cur = div_start;
        end
        else
        begin : g_rest
            assign cur = div_reg[d];
        end

        always_comb
        begin
            logic [32:0] acc;
            logic        red_take;
            div_next = cur;
            for (int k = 0; k < 3; k++)
            begin
                acc = {cur.rem[k], (d == 0) ? cur.lsb[k] : 1'b0};
                if (acc >= {1'b0, cur.len})
                begin
                    div_next.rem[k] = 32'(acc - {1'b0, cur.len});
                    div_next.q[k] = {cur.q[k][29:0], 1'b1};
                end
                else
                begin
                    div_next.rem[k] = acc[31:0];
                    div_next.q[k] = {cur.q[k][29:0], 1'b0};
                end
            end
            red_take = (d < 8) && ({1'b0, cur.r} >= RED_SUB);
            if (red_take)
                div_next.r = 56'({1'b0, cur.r} - RED_SUB);
            if (red_take && d == 6)
                div_next.quad[1] = 1'b1;
            if (red_take && d == 7)
                div_next.quad[0] = 1'b1;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[d+1] <= div_next;
        end
    end

    // CORDIC seed: signed unit axis and residual angle.
    always_comb
    begin
        cordic_start.x = K40;
        cordic_start.y = '0;
        cordic_start.z = $signed(53'(div_reg[31].r));
        for (int k = 0; k < 3; k++)
        begin
            cordic_start.u[k] = div_reg[31].neg[k] ? (32'd0 - {1'b0, div_reg[31].q[k]})
                                                   : {1'b0, div_reg[31].q[k]};
        end
        cordic_start.quad = div_reg[31].quad;
        cordic_start.zero = div_reg[31].zero;
    end

    // Rotation-mode CORDIC, one micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [52:0] AT = aar_pkg::atan48(i);
        aar_pkg::cordic_stage_t cur;
        aar_pkg::cordic_stage_t cordic_next;
        logic signed [43:0]     dx;
        logic signed [43:0]     dy;

        if (i == 0)
        begin : g_first
            assign cur = cordic_start;
        end
        else
        begin : g_rest
            assign cur = cordic_reg[i];
        end

        assign dx = cur.y >>> i;
        assign dy = cur.x >>> i;

        always_comb
        begin
            cordic_next = cur;
            if (!cur.z[52])
            begin
                cordic_next.x = cur.x - dx;
                cordic_next.y = cur.y + dy;
                cordic_next.z = cur.z - AT;
            end
            else
            begin
                cordic_next.x = cur.x + dx;
                cordic_next.y = cur.y - dy;
                cordic_next.z = cur.z + AT;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                cordic_reg[i+1] <= cordic_next;
        end
    end

    // Quadrant mapping, rounding to Q30 and one minus cosine.
    always_comb
    begin
        logic signed [44:0] xe;
        logic signed [44:0] ye;
        logic signed [44:0] cs_raw;
        logic signed [44:0] sn_raw;
        logic signed [44:0] cs_rnd;
        logic signed [44:0] sn_rnd;
        xe = 45'(cordic_reg[CORDIC_STEPS].x);
        ye = 45'(cordic_reg[CORDIC_STEPS].y);
        unique case (cordic_reg[CORDIC_STEPS].quad)
            2'd0:
            begin
                cs_raw = xe;
                sn_raw = ye;
            end
            2'd1:
            begin
                cs_raw = -ye;
                sn_raw = xe;
            end
            2'd2:
            begin
                cs_raw = -xe;
                sn_raw = -ye;
            end
            default:
            begin
                cs_raw = ye;
                sn_raw = -xe;
            end
        endcase
        cs_rnd = (cs_raw + 45'sd512) >>> 10;
        sn_rnd = (sn_raw + 45'sd512) >>> 10;
        post1_next.cs = aar_pkg::clamp30(36'(cs_rnd));
        post1_next.sn = aar_pkg::clamp30(36'(sn_rnd));
        post1_next.t = 33'(aar_pkg::ONE30) - 33'(post1_next.cs);
        post1_next.u = cordic_reg[CORDIC_STEPS].u;
        post1_next.zero = cordic_reg[CORDIC_STEPS].zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            post1_reg <= post1_next;
    end

    // Axis products and axis-times-sine products.
    always_comb
    begin
        logic signed [32:0] ux;
        logic signed [32:0] uy;
        logic signed [32:0] uz;
        logic signed [32:0] sn;
        ux = 33'($signed(post1_reg.u[0]));
        uy = 33'($signed(post1_reg.u[1]));
        uz = 33'($signed(post1_reg.u[2]));
        sn = 33'(post1_reg.sn);
        post2_next.cs = post1_reg.cs;
        post2_next.t = post1_reg.t;
        post2_next.uu[aar_pkg::UU_XX] = 32'(aar_pkg::mul30(ux, ux));
        post2_next.uu[aar_pkg::UU_YY] = 32'(aar_pkg::mul30(uy, uy));
        post2_next.uu[aar_pkg::UU_ZZ] = 32'(aar_pkg::mul30(uz, uz));
        post2_next.uu[aar_pkg::UU_XY] = 32'(aar_pkg::mul30(ux, uy));
        post2_next.uu[aar_pkg::UU_XZ] = 32'(aar_pkg::mul30(ux, uz));
        post2_next.uu[aar_pkg::UU_YZ] = 32'(aar_pkg::mul30(uy, uz));
        post2_next.us[aar_pkg::US_X] = 32'(aar_pkg::mul30(ux, sn));
        post2_next.us[aar_pkg::US_Y] = 32'(aar_pkg::mul30(uy, sn));
        post2_next.us[aar_pkg::US_Z] = 32'(aar_pkg::mul30(uz, sn));
        post2_next.zero = post1_reg.zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            post2_reg <= post2_next;
    end

    // Scale the axis products by one minus cosine.
    always_comb
    begin
        post3_next.cs = post2_reg.cs;
        for (int m = 0; m < 6; m++)
            post3_next.ut[m] = 33'(aar_pkg::mul30(33'($signed(post2_reg.uu[m])), post2_reg.t));
        post3_next.us = post2_reg.us;
        post3_next.zero = post2_reg.zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            post3_reg <= post3_next;
    end

    // Rodrigues sums with clamping; a zero vector gives the identity.
    always_comb
    begin
        logic signed [35:0] cs;
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        logic signed [35:0] zs;
        logic signed [35:0] xy;
        logic signed [35:0] xz;
        logic signed [35:0] yz;
        cs = 36'(post3_reg.cs);
        xs = 36'($signed(post3_reg.us[aar_pkg::US_X]));
        ys = 36'($signed(post3_reg.us[aar_pkg::US_Y]));
        zs = 36'($signed(post3_reg.us[aar_pkg::US_Z]));
        xy = 36'($signed(post3_reg.ut[aar_pkg::UU_XY]));
        xz = 36'($signed(post3_reg.ut[aar_pkg::UU_XZ]));
        yz = 36'($signed(post3_reg.ut[aar_pkg::UU_YZ]));
        if (post3_reg.zero)
        begin
            res_next = '0;
            res_next[0] = aar_pkg::ONE30;
            res_next[4] = aar_pkg::ONE30;
            res_next[8] = aar_pkg::ONE30;
        end
        else
        begin
            res_next[0] = aar_pkg::clamp30(cs + 36'($signed(post3_reg.ut[aar_pkg::UU_XX])));
            res_next[1] = aar_pkg::clamp30(xy - zs);
            res_next[2] = aar_pkg::clamp30(xz + ys);
            res_next[3] = aar_pkg::clamp30(xy + zs);
            res_next[4] = aar_pkg::clamp30(cs + 36'($signed(post3_reg.ut[aar_pkg::UU_YY])));
            res_next[5] = aar_pkg::clamp30(yz - xs);
            res_next[6] = aar_pkg::clamp30(xz - ys);
            res_next[7] = aar_pkg::clamp30(yz + xs);
            res_next[8] = aar_pkg::clamp30(cs + 36'($signed(post3_reg.ut[aar_pkg::UU_ZZ])));
        end
    end

    // Output register and skid register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= vld_reg[NPIPE-1];
        end
        else if (vld_reg[NPIPE-1])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid data.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_reg <= res_next;
        end
        else
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign m00 = $signed(out_reg[0]);
    assign m01 = $signed(out_reg[1]);
    assign m02 = $signed(out_reg[2]);
    assign m10 = $signed(out_reg[3]);
    assign m11 = $signed(out_reg[4]);
    assign m12 = $signed(out_reg[5]);
    assign m20 = $signed(out_reg[6]);
    assign m21 = $signed(out_reg[7]);
    assign m22 = $signed(out_reg[8]);

endmodule
